// ===== sv/acl_pkg.sv =====
// shared types and codes for the fully associative lru cache directory
// request and response words, operation codes, selection status flags
// no dependencies
package acl_pkg;

    localparam int OPCODE_BITS = 2;
    localparam int KEY_BITS    = 32;
    localparam int INDEX_BITS  = 7;
    localparam int TIME_BITS   = 32;

    localparam logic [OPCODE_BITS-1:0] OP_LOOKUP    = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_LOAD_DONE = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_EVICT     = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_FLUSH     = 2'd3;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [KEY_BITS-1:0]    key_tag;
        logic                   async_load;
        logic                   in_place;
        logic [INDEX_BITS-1:0]  target_entry;
        logic [TIME_BITS-1:0]   now_time;
    } req_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] entry_index;
        logic                  hit;
        logic                  replaced;
        logic                  status;
    } rsp_t;

    // running results of one scan over the directory
    typedef struct packed {
        logic found;
        logic found_pin;
        logic free_ok;
        logic old_ok;
    } sel_flags_t;

endpackage

// ===== sv/acl_mem.sv =====
// directory storage: one write port, one read port with registered read data
// no dependencies
module acl_mem #(
    parameter int DEPTH     = 128,
    parameter int WIDTH     = 66,
    parameter int ADDR_BITS = 7
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acl_sel.sv =====
// scan trackers: first tag match, first free entry and oldest idle entry
// depends on acl_pkg for the status flag struct and the time width
module acl_sel #(
    parameter int IDX_BITS = 7,
    parameter int TAG_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   sample,
    input  logic [IDX_BITS-1:0]    idx,
    input  logic                   ent_valid,
    input  logic                   ent_pin,
    input  logic [TAG_BITS-1:0]    ent_tag,
    input  logic [acl_pkg::TIME_BITS-1:0] ent_time,
    input  logic [TAG_BITS-1:0]    key,
    output acl_pkg::sel_flags_t    flags,
    output logic [IDX_BITS-1:0]    found_idx,
    output logic [IDX_BITS-1:0]    free_idx,
    output logic [IDX_BITS-1:0]    old_idx
);

    acl_pkg::sel_flags_t flags_reg, flags_next;
    logic [IDX_BITS-1:0] found_idx_reg, found_idx_next;
    logic [IDX_BITS-1:0] free_idx_reg, free_idx_next;
    logic [IDX_BITS-1:0] old_idx_reg, old_idx_next;
    logic [acl_pkg::TIME_BITS-1:0] old_time_reg, old_time_next;

    always_comb
    begin
        flags_next     = flags_reg;
        found_idx_next = found_idx_reg;
        free_idx_next  = free_idx_reg;
        old_idx_next   = old_idx_reg;
        old_time_next  = old_time_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (sample)
        begin
            if (!flags_reg.found && ent_valid && (ent_tag == key))
            begin
                flags_next.found     = 1'b1;
                flags_next.found_pin = ent_pin;
                found_idx_next       = idx;
            end
            if (!flags_reg.free_ok && !ent_valid && !ent_pin)
            begin
                flags_next.free_ok = 1'b1;
                free_idx_next      = idx;
            end
            // strict compare keeps the lowest index on equal times
            if (ent_valid && !ent_pin && (!flags_reg.old_ok || (ent_time < old_time_reg)))
            begin
                flags_next.old_ok = 1'b1;
                old_idx_next      = idx;
                old_time_next     = ent_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
        old_time_reg  <= old_time_next;
    end

    assign flags     = flags_reg;
    assign found_idx = found_idx_reg;
    assign free_idx  = free_idx_reg;
    assign old_idx   = old_idx_reg;

endmodule

// ===== sv/assoc_cache_lru_pinned.sv =====
// lookup, evict and flush scan the directory one entry per cycle from the memory read port:
// after the scan, drain and resolve states register the result word, and the done state
// moves it to the response register once no held response is stalled; only then is the
// next request taken; load finished is a read-modify-write of one entry
// after reset a clearing pass writes every entry to zero, with req_stall held high
// depends on acl_pkg, acl_mem, acl_sel
module assoc_cache_lru_pinned #(
    parameter int ENTRIES  = 128,
    parameter int TAG_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  acl_pkg::req_t req_word,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output acl_pkg::rsp_t rsp_word
);

    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int TIME_BITS = acl_pkg::TIME_BITS;
    localparam int OUT_BITS  = acl_pkg::INDEX_BITS;
    localparam int WORD_BITS = 2 + TAG_BITS + TIME_BITS;
    localparam int V_POS     = WORD_BITS - 1;
    localparam int P_POS     = WORD_BITS - 2;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_DRAIN   = 3'd3;
    localparam logic [2:0] ST_RESOLVE = 3'd4;
    localparam logic [2:0] ST_LDRD    = 3'd5;
    localparam logic [2:0] ST_LDWR    = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] cnt_reg, cnt_next;
    acl_pkg::req_t       req_reg, req_next;
    logic                rd_vld_reg;
    logic [IDX_BITS-1:0] rd_idx_reg;
    logic                flushed_reg, flushed_next;
    acl_pkg::rsp_t       res_reg, res_next;
    logic                rsp_valid_reg, rsp_valid_next;
    acl_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 mem_we;
    logic [IDX_BITS-1:0]  mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_BITS-1:0]  mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    acl_pkg::sel_flags_t  sel_flags;
    logic [IDX_BITS-1:0]  found_idx, free_idx, old_idx, take_idx;
    logic [TAG_BITS-1:0]  key_w;
    logic                 target_ok;
    logic [IDX_BITS-1:0]  target_addr;
    logic                 new_pin;

    assign key_w       = TAG_BITS'(req_reg.key_tag);
    assign target_ok   = 32'(req_reg.target_entry) < ENTRIES;
    assign target_addr = IDX_BITS'(req_reg.target_entry);
    assign take_idx    = sel_flags.free_ok ? free_idx : old_idx;
    assign new_pin     = req_reg.async_load && !req_reg.in_place;

    acl_mem #(
        .DEPTH     (ENTRIES),
        .WIDTH     (WORD_BITS),
        .ADDR_BITS (IDX_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    acl_sel #(
        .IDX_BITS (IDX_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (state_reg == ST_IDLE),
        .sample    (rd_vld_reg),
        .idx       (rd_idx_reg),
        .ent_valid (mem_rdata[V_POS]),
        .ent_pin   (mem_rdata[P_POS]),
        .ent_tag   (mem_rdata[TIME_BITS +: TAG_BITS]),
        .ent_time  (mem_rdata[TIME_BITS-1:0]),
        .key       (key_w),
        .flags     (sel_flags),
        .found_idx (found_idx),
        .free_idx  (free_idx),
        .old_idx   (old_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        flushed_next   = flushed_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req_word;
                    cnt_next     = '0;
                    flushed_next = 1'b0;
                    if (req_word.opcode == acl_pkg::OP_LOAD_DONE)
                    begin
                        state_next = ST_LDRD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_re   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                unique case (req_reg.opcode)
                    acl_pkg::OP_LOOKUP:
                    begin
                        if (sel_flags.found)
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = found_idx;
                            mem_wdata            = {1'b1, sel_flags.found_pin, key_w,
                                                    req_reg.now_time};
                            res_next.entry_index = OUT_BITS'(found_idx);
                            res_next.hit         = 1'b1;
                        end
                        else if (sel_flags.free_ok || sel_flags.old_ok)
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = take_idx;
                            mem_wdata            = {1'b1, new_pin, key_w, req_reg.now_time};
                            res_next.entry_index = OUT_BITS'(take_idx);
                            res_next.replaced    = !sel_flags.free_ok;
                        end
                        else
                        begin
                            res_next.status = 1'b1;
                        end
                    end
                    acl_pkg::OP_EVICT:
                    begin
                        if (sel_flags.old_ok)
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = old_idx;
                            res_next.entry_index = OUT_BITS'(old_idx);
                            res_next.replaced    = 1'b1;
                        end
                        else
                        begin
                            res_next.status = 1'b1;
                        end
                    end
                    acl_pkg::OP_FLUSH:
                    begin
                        res_next.replaced = flushed_reg;
                    end
                    acl_pkg::OP_LOAD_DONE:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_LDRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = target_addr;
                state_next = ST_LDWR;
            end
            ST_LDWR:
            begin
                // only the pin changes, whatever the entry holds
                if (target_ok)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = target_addr;
                    mem_wdata        = mem_rdata;
                    mem_wdata[P_POS] = 1'b0;
                end
                res_next             = '0;
                res_next.entry_index = req_reg.target_entry;
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase

        // flush clears idle entries as their words come back from the scan
        if (rd_vld_reg && (req_reg.opcode == acl_pkg::OP_FLUSH) &&
            mem_rdata[V_POS] && !mem_rdata[P_POS])
        begin
            mem_we       = 1'b1;
            mem_waddr    = rd_idx_reg;
            mem_wdata    = '0;
            flushed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            flushed_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= (state_reg == ST_SCAN);
            flushed_reg   <= flushed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= cnt_reg;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

// ===== sv/acl_check.sv =====
// port-level checks for assoc_cache_lru_pinned, attached by bind
// depends on acl_pkg and the top level
module acl_check (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input acl_pkg::rsp_t rsp_word
);

    // one request at a time: a taken word closes the request side
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one still in progress");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status |->
            (rsp_word.entry_index == '0) && !rsp_word.hit && !rsp_word.replaced)
        else $error("error word carries index, hit or replaced");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.hit |-> !rsp_word.replaced && !rsp_word.status)
        else $error("hit word also reports eviction or error");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled response word changed or dropped");

endmodule

bind assoc_cache_lru_pinned acl_check u_acl_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
